// ===== src/fwsr_pkg.sv =====
package fwsr_pkg;

    localparam int DEPTH   = 16;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [VALUE_W-1:0]  wdata;
        logic [ADDR_W-1:0]   raddr;
    } ram_req_t;

endpackage

// ===== src/fwsr_ram.sv =====
module fwsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fwsr_seq.sv =====
module fwsr_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  fwsr_pkg::req_t            req,
    input  logic                      out_free,
    output logic                      done,
    output fwsr_pkg::rsp_t            result,
    output fwsr_pkg::ram_req_t        ram_req,
    input  logic [fwsr_pkg::VALUE_W-1:0] ram_rdata
);

    import fwsr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_REPORT
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [OCC_W-1:0]    kept_reg, kept_next;
    logic [ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                hit_reg, hit_next;
    logic [1:0]          status_reg, status_next;

    logic match;
    logic last;

    assign match = (ram_rdata == value_reg);
    assign last  = ((OCC_W'(rd_idx_reg) + OCC_W'(1)) == occ_reg);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        occ_next      = occ_reg;
        kept_next     = kept_reg;
        rd_idx_next   = rd_idx_reg;
        hit_next      = hit_reg;
        status_next   = status_reg;
        req_ready     = 1'b0;
        done          = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = kept_reg[ADDR_W-1:0];
        ram_req.wdata = ram_rdata;
        ram_req.raddr = (state_reg == S_WALK) ? (rd_idx_reg + ADDR_W'(1)) : '0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd_next    = req.command;
                    value_next  = req.value;
                    hit_next    = 1'b0;
                    kept_next   = '0;
                    rd_idx_next = '0;
                    status_next = STATUS_OK;
                    state_next  = S_REPORT;
                    unique case (req.command)
                        CMD_INSERT:
                        begin
                            if (occ_reg == OCC_W'(DEPTH))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = occ_reg[ADDR_W-1:0];
                                ram_req.wdata = req.value;
                                occ_next      = occ_reg + OCC_W'(1);
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        CMD_UNUSED:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                rd_idx_next = rd_idx_reg + ADDR_W'(1);
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else if (cmd_reg == CMD_REMOVE)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = kept_reg[ADDR_W-1:0];
                    kept_next     = kept_reg + OCC_W'(1);
                end
                if (last)
                begin
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        occ_next = match ? kept_reg : (kept_reg + OCC_W'(1));
                    end
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                done = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_INSERT;
            value_reg  <= '0;
            occ_reg    <= '0;
            kept_reg   <= '0;
            rd_idx_reg <= '0;
            hit_reg    <= 1'b0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            value_reg  <= value_next;
            occ_reg    <= occ_next;
            kept_reg   <= kept_next;
            rd_idx_reg <= rd_idx_next;
            hit_reg    <= hit_next;
            status_reg <= status_next;
        end
    end

    assign result.status = status_reg;
    assign result.found  = hit_reg;
    assign result.count  = COUNT_W'(occ_reg);

endmodule

// ===== src/fifo_with_search_and_remove.sv =====
// Bounded FIFO of signed 32-bit values with insert, remove-all-equal and
// search commands; one response beat per request beat. Insert, an unused
// command code, and remove or search on an empty queue go from accept
// straight to the report state, then to the response register. Remove and
// search walk every stored entry through the single read port of the entry
// RAM, one entry per cycle; remove writes the survivors back through the
// write port in the same pass. The request side is ready only while the
// sequencer is idle. A finished response waits in an output register, so a
// new request is taken while the previous response is still pending.
module fifo_with_search_and_remove (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fwsr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fwsr_pkg::rsp_t rsp
);

    import fwsr_pkg::*;

    ram_req_t           ram_req;
    logic [VALUE_W-1:0] ram_rdata;
    rsp_t               result;
    logic               done;
    logic               out_free;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    assign out_free = !rsp_valid_reg || rsp_ready;

    fwsr_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .out_free  (out_free),
        .done      (done),
        .result    (result),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    fwsr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // hold the response beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= result;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
